@@ hdl/tdl_pkg.sv @@
// Shared types and constants for the timestamped delay line.
// Word layouts, opcodes, register indexes and the time-gap helper.
// No dependencies.
package tdl_pkg;

  localparam int TIME_BITS  = 48;
  localparam int VALUE_BITS = 32;
  localparam int POS_IO_W   = 6;
  localparam int SIZE_CFG_W = 7;
  localparam int STEP_W     = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [1:0] {
    OP_FILL      = 2'd0,
    OP_APPEND    = 2'd1,
    OP_READ_TIME = 2'd2,
    OP_READ_POS  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SIZE = 1'b0,
    CFG_TIME_STEP   = 1'b1
  } cfg_idx_t;

  typedef logic signed [TIME_BITS-1:0]  tick_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef struct packed {
    op_t                 opcode;
    tick_t               sample_time;
    val_t                sample_value;
    logic [POS_IO_W-1:0] delay_position;
  } in_word_t;

  typedef struct packed {
    val_t                out_value;
    tick_t               out_time;
    logic [POS_IO_W-1:0] out_position;
    logic                hit;
  } out_word_t;

  // one ring entry
  typedef struct packed {
    tick_t t;
    val_t  v;
  } entry_t;

  typedef struct packed {
    logic shift_en;   // move one place toward cell 0
    logic take_wrap;  // last cell of the ring: load from the wrap bus
    logic wr_full;    // write time and value
    logic wr_val;     // write value only
  } cell_ctl_t;

  // |a - b|; the true distance of two signed times always fits TIME_BITS unsigned
  function automatic logic [TIME_BITS-1:0] abs_gap(tick_t a, tick_t b);
    logic [TIME_BITS-1:0] ab;
    logic [TIME_BITS-1:0] ba;
    ab = TIME_BITS'(a - b);
    ba = TIME_BITS'(b - a);
    return (a < b) ? ba : ab;
  endfunction

endpackage

@@ hdl/tdl_cell.sv @@
// One storage cell of the delay-line ring: a (time, value) pair.
// Shifts toward its lower neighbor or takes a direct write.
// Depends on tdl_pkg.
module tdl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tdl_pkg::cell_ctl_t ctl,
  input  tdl_pkg::entry_t    nbr_in,
  input  tdl_pkg::entry_t    wrap_in,
  input  tdl_pkg::entry_t    wr_entry,
  output tdl_pkg::entry_t    q
);
  import tdl_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (ctl.wr_full) begin
      q_r <= wr_entry;
    end else if (ctl.wr_val) begin
      q_r.v <= wr_entry.v;
    end else if (ctl.shift_en) begin
      q_r <= ctl.take_wrap ? wrap_in : nbr_in;
    end
  end

  assign q = q_r;

endmodule

@@ hdl/timestamped_delay_line_top.sv @@
// Timestamped delay line: ring of (time, value) pairs held in a row of cells that
// rotates one place per cycle while an operation shifts it; cell 0 is the single
// inspection point, and appends write cell 0 or the last ring cell.
// One word in flight; the next word is taken the cycle after the result registers,
// and no new word is taken before then. Sync active-low reset: store 0, head 0, size 1, step 1.
module timestamped_delay_line_top #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tdl_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tdl_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tdl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tdl_pkg::*;

  localparam int SW = $clog2(MAX_DEPTH + 1);
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = (SW > POS_IO_W) ? SW : POS_IO_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_ROT  = 8'b0000_0100,
    S_ACT  = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_FILL = 8'b0010_0000,
    S_RET  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [PW-1:0]         head_r, head_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic                  adv_r, adv_nxt;
  logic                  stop_r, stop_nxt;
  logic                  out_valid_r, out_valid_nxt;

  op_t                   op_r, op_nxt;
  tick_t                 t_r, t_nxt;
  val_t                  v_r, v_nxt;
  logic [DW-1:0]         d_r, d_nxt;
  tick_t                 gen_r, gen_nxt;
  logic [TIME_BITS-1:0]  best_gap_r, best_gap_nxt;
  tick_t                 best_t_r, best_t_nxt;
  val_t                  best_v_r, best_v_nxt;
  logic [PW-1:0]         best_pos_r, best_pos_nxt;
  tick_t                 head_t_r, head_t_nxt;
  tick_t                 tail_t_r, tail_t_nxt;
  val_t                  tail_v_r, tail_v_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic [SIZE_CFG_W-1:0] size_raw;
  logic [SW-1:0]         size_w;
  logic [SW-1:0]         cnt_inc;
  logic [SW-1:0]         last_idx;
  logic                  head_zero;
  logic                  size_one;
  logic                  shifting;
  logic                  act_eq;
  logic                  act_newer;
  logic                  act_wr_last;
  logic                  act_wr_head;
  logic [TIME_BITS-1:0]  gap0;
  logic [TIME_BITS-1:0]  step_ext;
  entry_t                wrap_src;
  entry_t                act_entry;
  entry_t                c0;
  out_word_t             result_w;

  entry_t                cell_q [MAX_DEPTH];

  // ---------------- cell row ----------------
  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
    entry_t    nbr;
    cell_ctl_t ctl;
    assign ctl.shift_en  = shifting && (SW'(k) < size_r);
    assign ctl.take_wrap = (SW'(k) == last_idx);
    assign ctl.wr_full   = act_wr_last && (SW'(k) == last_idx);
    assign ctl.wr_val    = act_wr_head && (k == 0);
    if (k == MAX_DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end
    tdl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .nbr_in   (nbr),
      .wrap_in  (wrap_src),
      .wr_entry (act_entry),
      .q        (cell_q[k])
    );
  end

  assign c0        = cell_q[0];
  assign cnt_inc   = cnt_r + SW'(1);
  assign last_idx  = size_r - SW'(1);
  assign head_zero = (head_r == '0);
  assign size_one  = (size_r == SW'(1));
  assign shifting  = (state_r == S_ROT) || (state_r == S_WALK) ||
                     (state_r == S_RET) || (state_r == S_FILL);
  assign step_ext  = TIME_BITS'(step_r);
  assign gap0      = abs_gap(t_r, c0.t);

  // fill feeds generated entries in at the ring's far end
  assign wrap_src  = (state_r == S_FILL) ? entry_t'{t: gen_r, v: v_r} : c0;
  assign act_entry = '{t: t_r, v: v_r};

  // append: cell 0 holds the head, the last ring cell the slot just before it
  assign act_eq      = (t_r == c0.t);
  assign act_newer   = (c0.t < t_r);
  assign act_wr_last = (state_r == S_ACT) && (size_one || (!act_eq && act_newer));
  assign act_wr_head = (state_r == S_ACT) && !size_one && act_eq;

  // size register write: zero reads as one, saturate at the built depth
  assign size_raw = cfg_wdata[SIZE_CFG_W-1:0];
  always_comb begin
    if (size_raw == '0) begin
      size_w = SW'(1);
    end else if (32'(size_raw) > 32'(MAX_DEPTH)) begin
      size_w = SW'(MAX_DEPTH);
    end else begin
      size_w = SW'(size_raw);
    end
  end

  // result word of the finished operation
  always_comb begin
    result_w = '0;
    unique case (op_r)
      OP_READ_TIME: begin
        if (t_r != head_t_r && t_r == tail_t_r) begin
          result_w.out_value    = tail_v_r;
          result_w.out_time     = tail_t_r;
          result_w.out_position = POS_IO_W'(last_idx);
          result_w.hit          = 1'b1;
        end else if (t_r != head_t_r && (t_r < tail_t_r || head_t_r < t_r)) begin
          result_w = '0;
        end else begin
          result_w.out_value    = best_v_r;
          result_w.out_time     = best_t_r;
          result_w.out_position = POS_IO_W'(best_pos_r);
          result_w.hit          = 1'b1;
        end
      end
      OP_READ_POS: begin
        result_w.out_value    = best_v_r;
        result_w.out_time     = best_t_r;
        result_w.out_position = POS_IO_W'(best_pos_r);
      end
      default: result_w = '0;
    endcase
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    step_nxt      = step_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    adv_nxt       = adv_r;
    stop_nxt      = stop_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    t_nxt         = t_r;
    v_nxt         = v_r;
    d_nxt         = d_r;
    gen_nxt       = gen_r;
    best_gap_nxt  = best_gap_r;
    best_t_nxt    = best_t_r;
    best_v_nxt    = best_v_r;
    best_pos_nxt  = best_pos_r;
    head_t_nxt    = head_t_r;
    tail_t_nxt    = tail_t_r;
    tail_v_nxt    = tail_v_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_SIZE: begin
          size_nxt = size_w;
          if (SW'(head_r) >= size_w) begin
            head_nxt = '0;
          end
        end
        CFG_TIME_STEP: step_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.opcode;
          t_nxt    = in_data.sample_time;
          v_nxt    = in_data.sample_value;
          d_nxt    = DW'(in_data.delay_position);
          gen_nxt  = in_data.sample_time;
          cnt_nxt  = '0;
          adv_nxt  = 1'b0;
          stop_nxt = 1'b0;
          unique case (in_data.opcode)
            OP_FILL:      state_nxt = S_FILL;
            OP_APPEND:    state_nxt = head_zero ? S_ACT : S_ROT;
            OP_READ_TIME: state_nxt = head_zero ? S_WALK : S_ROT;
            OP_READ_POS:  state_nxt = S_PREP;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        // delay position modulo size, one subtraction a cycle
        if (d_r >= DW'(size_r)) begin
          d_nxt = d_r - DW'(size_r);
        end else begin
          state_nxt = head_zero ? S_WALK : S_ROT;
        end
      end
      S_ROT: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == SW'(head_r)) begin
          cnt_nxt   = '0;
          state_nxt = (op_r == OP_APPEND) ? S_ACT : S_WALK;
        end
      end
      S_ACT: begin
        adv_nxt   = !size_one && !act_eq && act_newer;
        cnt_nxt   = '0;
        state_nxt = head_zero ? S_DONE : S_RET;
      end
      S_WALK: begin
        // cell 0 holds delay position cnt_r
        if (op_r == OP_READ_TIME) begin
          if (cnt_r == '0) begin
            best_gap_nxt = gap0;
            best_t_nxt   = c0.t;
            best_v_nxt   = c0.v;
            best_pos_nxt = '0;
            head_t_nxt   = c0.t;
          end else if (!stop_r) begin
            if (best_gap_r > gap0) begin
              best_gap_nxt = gap0;
              best_t_nxt   = c0.t;
              best_v_nxt   = c0.v;
              best_pos_nxt = PW'(cnt_r);
            end else begin
              stop_nxt = 1'b1;
            end
          end
          if (cnt_inc == size_r) begin
            tail_t_nxt = c0.t;
            tail_v_nxt = c0.v;
          end
        end else if (DW'(cnt_r) == d_r) begin
          best_t_nxt   = c0.t;
          best_v_nxt   = c0.v;
          best_pos_nxt = PW'(cnt_r);
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc == size_r) begin
          cnt_nxt   = '0;
          state_nxt = head_zero ? S_DONE : S_RET;
        end
      end
      S_FILL: begin
        gen_nxt = gen_r - step_ext;
        cnt_nxt = cnt_inc;
        if (cnt_inc == size_r) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_RET: begin
        // rotate the rest of the way back to slot order
        cnt_nxt = cnt_inc;
        if (cnt_inc == size_r - SW'(head_r)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_w;
          state_nxt     = S_IDLE;
          if (op_r == OP_FILL) begin
            head_nxt = '0;
          end else if (op_r == OP_APPEND && adv_r) begin
            head_nxt = head_zero ? PW'(last_idx) : head_r - PW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SW'(1);
      step_r      <= STEP_W'(1);
      head_r      <= '0;
      cnt_r       <= '0;
      adv_r       <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      step_r      <= step_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      adv_r       <= adv_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    t_r        <= t_nxt;
    v_r        <= v_nxt;
    d_r        <= d_nxt;
    gen_r      <= gen_nxt;
    best_gap_r <= best_gap_nxt;
    best_t_r   <= best_t_nxt;
    best_v_r   <= best_v_nxt;
    best_pos_r <= best_pos_nxt;
    head_t_r   <= head_t_nxt;
    tail_t_r   <= tail_t_nxt;
    tail_v_r   <= tail_v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(head_r) < size_r)
    else $error("head slot outside active ring");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside done state");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_FILL) |-> cnt_r < size_r)
    else $error("walk counter past active size");

endmodule
